[hdl/samn_pkg.sv]
// Shared types and constants for the sensor average min/max normaliser.
`timescale 1ns / 1ps

package samn_pkg;

  localparam int NCH      = 6;
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int LEVEL_W  = 7;
  localparam int FIELD_W  = 9;
  localparam int CEN_W    = 7;
  localparam int CH_IDX_W = 3;
  localparam int DATA_W   = 72;

  // Shared divider: numerator and denominator widths, quotient bits per cycle
  localparam int DIV_NUM_W = 20;
  localparam int DIV_DEN_W = 14;
  localparam int DIV_STEPS = 2;

  localparam int LEVEL_MAX = 100;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [DIV_NUM_W-1:0] div_num_t;
  typedef logic [DIV_DEN_W-1:0] div_den_t;
  typedef logic [CH_IDX_W-1:0]  ch_idx_t;

  localparam sample_t MIN_RESET [NCH] = '{12'd120, 12'd120, 12'd999, 12'd999, 12'd120, 12'd120};
  localparam sample_t MAX_RESET [NCH] =
    '{12'd2500, 12'd2500, 12'd999, 12'd999, 12'd2500, 12'd2500};

  // Centroid weights; outer channels carry no weight and are left out of the sum
  localparam logic [6:0] CEN_WEIGHT [NCH] = '{7'd0, 7'd1, 7'd15, 7'd65, 7'd79, 7'd0};
  localparam logic [NCH-1:0] CEN_MEMBER = 6'b011110;

  localparam ch_idx_t LAST_CH = 3'd5;

  typedef struct packed {
    logic     start;
    div_num_t num;
    div_den_t den;
  } div_req_t;

  typedef struct packed {
    logic     busy;
    logic     done;
    div_num_t quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_RANGE,
    ST_LEVEL_GO,
    ST_LEVEL_WAIT,
    ST_NEXT,
    ST_CEN_GO,
    ST_CEN_WAIT,
    ST_OUT
  } seq_state_t;

endpackage

[hdl/samn_div.sv]
// Shared restoring divider, DIV_STEPS quotient bits per cycle.
`timescale 1ns / 1ps

module samn_div (
  input  logic               clk,
  input  logic               rst,
  input  samn_pkg::div_req_t req,
  output samn_pkg::div_rsp_t rsp
);

  localparam int NUM_W  = samn_pkg::DIV_NUM_W;
  localparam int DEN_W  = samn_pkg::DIV_DEN_W;
  localparam int ITER   = NUM_W / samn_pkg::DIV_STEPS;
  localparam int ITER_W = $clog2(ITER + 1);

  logic              busy;
  logic              done;
  logic [ITER_W-1:0] cnt;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  den;

  logic [DEN_W-1:0]  rem_next;
  logic [NUM_W-1:0]  quo_next;
  logic [DEN_W:0]    trial;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int k = 0; k < samn_pkg::DIV_STEPS; k++) begin
      trial    = {rem_next, quo_next[NUM_W-1]};
      quo_next = {quo_next[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_next    = DEN_W'(trial - {1'b0, den});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == ITER_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= ITER_W'(ITER);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ITER_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

[hdl/sensor_avg_minmax_normalizer_core.sv]
// Top level: round accumulation, sequencer and datapath around the shared divider.
// A round that completes no average is taken in the idle state, and the block stays ready for the next.
// A completing round raises m_tvalid after up to 13 divisions, a range and a step state per
// channel and the output load, plus any m_tready stall.
// No new round is accepted until the sequencer has loaded the output of a completed set.
// Reset (rst, synchronous): clears sums and round count, loads range defaults, drops m_tvalid.
`timescale 1ns / 1ps

module sensor_avg_minmax_normalizer_core #(
  parameter int AVG_COUNT   = 12,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  // s_tdata, lowest bit up: sample_ch0[11:0], sample_ch1 .. sample_ch5 (12 bits each)
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [samn_pkg::DATA_W-1:0] s_tdata,
  // m_tdata, lowest bit up: level_ch0..level_ch5 (7 bits each), field_strength (9),
  // line_centroid (7), zero_span_mask (6), centroid_invalid (1), 7 zero bits
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [samn_pkg::DATA_W-1:0] m_tdata
);

  localparam int NCH      = samn_pkg::NCH;
  localparam int SAMPLE_W = samn_pkg::SAMPLE_W;

  // Keep only the low SAMPLE_BITS of each sample
  localparam samn_pkg::sample_t SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [4:0]          AVG_LAST   = 5'(AVG_COUNT);
  localparam samn_pkg::div_den_t  AVG_DEN    = samn_pkg::DIV_DEN_W'(AVG_COUNT);

  samn_pkg::seq_state_t state, state_next;
  samn_pkg::ch_idx_t    chan;
  logic [3:0]           round_count;
  samn_pkg::sum_t       channel_sum [NCH];
  samn_pkg::sample_t    channel_min [NCH];
  samn_pkg::sample_t    channel_max [NCH];

  samn_pkg::sample_t    avg;
  samn_pkg::level_t     level [NCH];
  logic [NCH-1:0]       zmask;
  samn_pkg::div_num_t   cen_num;
  samn_pkg::div_den_t   cen_den;
  logic [6:0]           cen;
  logic                 inv;

  samn_pkg::div_req_t   div_req;
  samn_pkg::div_rsp_t   div_rsp;

  logic                 in_acc;
  logic                 round_done;
  logic                 out_free;
  logic                 out_load;
  logic                 level_skip;
  samn_pkg::sample_t    lo, hi;
  samn_pkg::sample_t    span;
  samn_pkg::sample_t    offset;
  samn_pkg::div_num_t   level_num;
  samn_pkg::sample_t    sample [NCH];
  logic [samn_pkg::FIELD_W-1:0] field_strength;

  samn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Unpack and mask the six samples of the incoming round
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sample[c] = s_tdata[c*SAMPLE_W +: SAMPLE_W] & SAMPLE_MASK;
    end
  end

  assign in_acc     = s_tvalid && s_tready;
  assign round_done = ({1'b0, round_count} + 5'd1) >= AVG_LAST;
  assign out_free   = !m_tvalid || m_tready;

  // Range of the current channel, already widened by the range step
  assign lo         = channel_min[chan];
  assign hi         = channel_max[chan];
  assign level_skip = (hi <= lo) || (avg < lo);
  assign span       = hi - lo;
  assign offset     = avg - lo;
  // offset * 100 as shifts and adds
  assign level_num  = (samn_pkg::DIV_NUM_W'(offset) << 6) + (samn_pkg::DIV_NUM_W'(offset) << 5)
                    + (samn_pkg::DIV_NUM_W'(offset) << 2);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      samn_pkg::ST_IDLE: begin
        if (in_acc && round_done) state_next = samn_pkg::ST_AVG_GO;
      end
      samn_pkg::ST_AVG_GO:   state_next = samn_pkg::ST_AVG_WAIT;
      samn_pkg::ST_AVG_WAIT: begin
        if (div_rsp.done) state_next = samn_pkg::ST_RANGE;
      end
      samn_pkg::ST_RANGE:    state_next = samn_pkg::ST_LEVEL_GO;
      samn_pkg::ST_LEVEL_GO: begin
        state_next = level_skip ? samn_pkg::ST_NEXT : samn_pkg::ST_LEVEL_WAIT;
      end
      samn_pkg::ST_LEVEL_WAIT: begin
        if (div_rsp.done) state_next = samn_pkg::ST_NEXT;
      end
      samn_pkg::ST_NEXT: begin
        state_next = (chan == samn_pkg::LAST_CH) ? samn_pkg::ST_CEN_GO : samn_pkg::ST_AVG_GO;
      end
      samn_pkg::ST_CEN_GO: begin
        state_next = (cen_den == '0) ? samn_pkg::ST_OUT : samn_pkg::ST_CEN_WAIT;
      end
      samn_pkg::ST_CEN_WAIT: begin
        if (div_rsp.done) state_next = samn_pkg::ST_OUT;
      end
      samn_pkg::ST_OUT: begin
        if (out_free) state_next = samn_pkg::ST_IDLE;
      end
      default: state_next = samn_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, divider requests, output load
  always_comb begin
    s_tready      = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = samn_pkg::DIV_NUM_W'(channel_sum[chan]);
    div_req.den   = AVG_DEN;
    unique case (state)
      samn_pkg::ST_IDLE:     s_tready = 1'b1;
      samn_pkg::ST_AVG_GO:   div_req.start = 1'b1;
      samn_pkg::ST_LEVEL_GO: begin
        div_req.start = !level_skip;
        div_req.num   = level_num;
        div_req.den   = samn_pkg::DIV_DEN_W'(span);
      end
      samn_pkg::ST_CEN_GO: begin
        div_req.start = (cen_den != '0);
        div_req.num   = cen_num;
        div_req.den   = cen_den;
      end
      samn_pkg::ST_OUT: out_load = out_free;
      default: ;
    endcase
  end

  // Control state, sums and running range
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= samn_pkg::ST_IDLE;
      chan        <= '0;
      round_count <= '0;
      m_tvalid    <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        channel_sum[c] <= '0;
        channel_min[c] <= samn_pkg::MIN_RESET[c];
        channel_max[c] <= samn_pkg::MAX_RESET[c];
      end
    end else begin
      state <= state_next;
      if (in_acc) begin
        round_count <= round_done ? 4'd0 : 4'(round_count + 4'd1);
        for (int c = 0; c < NCH; c++) begin
          channel_sum[c] <= channel_sum[c] + samn_pkg::SUM_W'(sample[c]);
        end
        chan <= '0;
      end
      if (state == samn_pkg::ST_NEXT && chan != samn_pkg::LAST_CH) begin
        chan <= chan + 1'b1;
      end
      // Widen the range: minimum first, maximum only when the minimum holds
      if (state == samn_pkg::ST_RANGE) begin
        if (avg < channel_min[chan]) begin
          channel_min[chan] <= avg;
        end else if (avg > channel_max[chan]) begin
          channel_max[chan] <= avg;
        end
      end
      if (out_load) begin
        for (int c = 0; c < NCH; c++) begin
          channel_sum[c] <= '0;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Per-round working values and the output register
  always_ff @(posedge clk) begin
    if (in_acc && round_done) begin
      zmask   <= '0;
      cen_num <= '0;
      cen_den <= '0;
    end
    if (state == samn_pkg::ST_AVG_WAIT && div_rsp.done) begin
      avg <= div_rsp.quo[SAMPLE_W-1:0];
    end
    // Accumulate centroid numerator and weight over the inner channels
    if (state == samn_pkg::ST_RANGE && samn_pkg::CEN_MEMBER[chan]) begin
      cen_num <= cen_num + samn_pkg::DIV_NUM_W'(avg)
                         * samn_pkg::DIV_NUM_W'(samn_pkg::CEN_WEIGHT[chan]);
      cen_den <= cen_den + samn_pkg::DIV_DEN_W'(avg);
    end
    if (state == samn_pkg::ST_LEVEL_GO && level_skip) begin
      level[chan] <= '0;
      if (hi == lo) zmask[chan] <= 1'b1;
    end
    if (state == samn_pkg::ST_LEVEL_WAIT && div_rsp.done) begin
      level[chan] <= (div_rsp.quo > samn_pkg::DIV_NUM_W'(samn_pkg::LEVEL_MAX))
                   ? samn_pkg::LEVEL_W'(samn_pkg::LEVEL_MAX)
                   : div_rsp.quo[samn_pkg::LEVEL_W-1:0];
    end
    if (state == samn_pkg::ST_CEN_GO && cen_den == '0) begin
      cen <= '0;
      inv <= 1'b1;
    end
    if (state == samn_pkg::ST_CEN_WAIT && div_rsp.done) begin
      cen <= div_rsp.quo[samn_pkg::CEN_W-1:0];
      inv <= 1'b0;
    end
    if (out_load) begin
      m_tdata <= {7'd0, inv, zmask, cen, field_strength,
                  level[5], level[4], level[3], level[2], level[1], level[0]};
    end
  end

  assign field_strength = 9'(level[0]) + 9'(level[1]) + 9'(level[4]) + 9'(level[5]);

  // Never start the divider while it is still busy
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == samn_pkg::ST_AVG_WAIT || state == samn_pkg::ST_LEVEL_WAIT ||
                      state == samn_pkg::ST_CEN_WAIT))
    else $error("divider finished outside a wait state");

  a_range_ordered: assert property (@(posedge clk) disable iff (rst)
    channel_min[chan] <= channel_max[chan])
    else $error("channel minimum above maximum");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == samn_pkg::ST_OUT))
    else $error("result raised outside the output step");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> !s_tready)
    else $error("input taken while a division runs");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the six-channel sensor average min/max normaliser.
`timescale 1ns / 1ps

module tb_top;

  localparam int NCH         = samn_pkg::NCH;
  localparam int SAMPLE_W    = samn_pkg::SAMPLE_W;
  localparam int LEVEL_W     = samn_pkg::LEVEL_W;
  localparam int AVG_ROUNDS  = 12;
  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLE_MASK = (1 << SAMPLE_BITS) - 1;
  localparam int SAMPLE_TOP  = (1 << SAMPLE_W) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 400;  // margin beyond the worst case of a completing round
  localparam int MAX_REPORTS = 10;

  // One result transaction as it sits in m_tdata[64:0]; the last member is the lowest.
  typedef struct packed {
    logic                       cen_invalid;
    logic [5:0]                 zero_span;
    logic [6:0]                 centroid;
    logic [8:0]                 field_sum;
    samn_pkg::level_t [NCH-1:0] lvl;
  } reading_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;

  // Predictor state: running sums, round counter and per-channel span
  logic [15:0]       round_sums [NCH];
  logic [3:0]        rounds_seen;
  samn_pkg::sample_t span_lo [NCH];
  samn_pkg::sample_t span_hi [NCH];

  reading_t pending_readings [$];
  reading_t got_rd;
  reading_t want_rd;

  int idle_pct;
  int stall_pct;
  int err_count;
  int cycle_count;
  int rounds_sent;
  int readings_checked;
  int invalid_seen;
  int zero_span_seen;

  sensor_avg_minmax_normalizer_core #(
    .AVG_COUNT  (AVG_ROUNDS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Model one accepted round; on the closing round of a set queue the expected reading.
  task automatic fold_round(input logic [71:0] word);
    reading_t rd;
    int c, a, lo, hi, lv, num, den;
    int avg [NCH];
    for (c = 0; c < NCH; c++)
      round_sums[c] = 16'(round_sums[c] + (word[c*SAMPLE_W +: SAMPLE_W] & SAMPLE_MASK));
    if (rounds_seen + 1 < AVG_ROUNDS) begin
      rounds_seen = 4'(rounds_seen + 1);
    end else begin
      rounds_seen = '0;
      rd = '0;
      for (c = 0; c < NCH; c++) begin
        a = round_sums[c] / AVG_ROUNDS;
        round_sums[c] = '0;
        avg[c] = a;
        // widen one side of the range only
        if (a < span_lo[c])
          span_lo[c] = a[SAMPLE_W-1:0];
        else if (a > span_hi[c])
          span_hi[c] = a[SAMPLE_W-1:0];
        lo = span_lo[c];
        hi = span_hi[c];
        if (hi <= lo || a < lo) begin
          lv = 0;
          if (hi == lo)
            rd.zero_span[c] = 1'b1;
        end else begin
          lv = (a - lo) * 100 / (hi - lo);
          if (lv > 100)
            lv = 100;
        end
        rd.lvl[c] = lv[LEVEL_W-1:0];
      end
      rd.field_sum = rd.lvl[0] + rd.lvl[1] + rd.lvl[4] + rd.lvl[5];
      num = avg[1] * 1 + avg[2] * 15 + avg[3] * 65 + avg[4] * 79;
      den = avg[1] + avg[2] + avg[3] + avg[4];
      if (den == 0) begin
        rd.centroid = '0;
        rd.cen_invalid = 1'b1;
      end else begin
        lv = num / den;
        rd.centroid = lv[6:0];
      end
      pending_readings.push_back(rd);
    end
  endtask

  // Offer one round on the slave side, idling at random first; return once accepted.
  task automatic push_round(input logic [71:0] word);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    rounds_sent++;
    fold_round(word);
  endtask

  task automatic show_reading(input string tag, input reading_t rd);
    $display("  %s lvl %0d %0d %0d %0d %0d %0d field %0d cen %0d zspan %b inv %b", tag,
             rd.lvl[0], rd.lvl[1], rd.lvl[2], rd.lvl[3], rd.lvl[4], rd.lvl[5],
             rd.field_sum, rd.centroid, rd.zero_span, rd.cen_invalid);
  endtask

  // Channels 2 and 3 start with min == max == 999; an average of exactly 999 leaves no span.
  task automatic test_zero_span();
    logic [71:0] word;
    int r, c;
    for (r = 0; r < AVG_ROUNDS; r++) begin
      for (c = 0; c < NCH; c++)
        word[c*SAMPLE_W +: SAMPLE_W] = 12'd999;
      push_round(word);
    end
  endtask

  // Inner channels dark, outer channels at the extremes: zero centroid weight.
  task automatic test_dark_inner();
    logic [71:0] word;
    int r;
    for (r = 0; r < AVG_ROUNDS; r++) begin
      word = '0;
      word[0*SAMPLE_W +: SAMPLE_W] = SAMPLE_TOP[SAMPLE_W-1:0];
      word[5*SAMPLE_W +: SAMPLE_W] = (r % 2) ? SAMPLE_TOP[SAMPLE_W-1:0] : '0;
      push_round(word);
    end
  endtask

  // Whole sets of rounds; each channel follows a pattern so that averages spread widely.
  task automatic test_random_sets(input int sender_idle, input int rx_stall, input int sets);
    logic [71:0] word;
    logic dark;
    int s, r, c, v;
    int mode [NCH];
    int base [NCH];
    idle_pct  = sender_idle;
    stall_pct = rx_stall;
    for (s = 0; s < sets; s++) begin
      dark = ($urandom_range(0, 11) == 0);
      for (c = 0; c < NCH; c++) begin
        mode[c] = $urandom_range(0, 9);
        base[c] = $urandom_range(0, SAMPLE_TOP);
      end
      for (r = 0; r < AVG_ROUNDS; r++) begin
        for (c = 0; c < NCH; c++) begin
          case (mode[c])
            0: v = 0;
            1: v = SAMPLE_TOP;
            2, 3, 4, 5: begin
              v = base[c] + int'($urandom_range(0, 127)) - 64;
              if (v < 0)
                v = 0;
              else if (v > SAMPLE_TOP)
                v = SAMPLE_TOP;
            end
            9: v = (r % 2) ? SAMPLE_TOP : 0;
            default: v = $urandom_range(0, SAMPLE_TOP);
          endcase
          if (dark && c >= 1 && c <= 4)
            v = 0;
          word[c*SAMPLE_W +: SAMPLE_W] = v[SAMPLE_W-1:0];
        end
        push_round(word);
      end
    end
  endtask

  // Receiver: stall at random at the falling edge
  always @(negedge clk)
    m_tready <= ($urandom_range(0, 99) >= stall_pct);

  // Compare each accepted reading with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_rd = m_tdata[64:0];
      if (pending_readings.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("unexpected reading at cycle %0d", cycle_count);
          show_reading("got ", got_rd);
        end
      end else begin
        want_rd = pending_readings.pop_front();
        readings_checked++;
        if (want_rd.cen_invalid)
          invalid_seen++;
        if (want_rd.zero_span != '0)
          zero_span_seen++;
        if (got_rd.lvl != want_rd.lvl || got_rd.field_sum != want_rd.field_sum ||
            got_rd.centroid != want_rd.centroid || got_rd.zero_span != want_rd.zero_span ||
            got_rd.cen_invalid != want_rd.cen_invalid || m_tdata[71:65] != '0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("reading %0d differs at cycle %0d (pad bits %b)", readings_checked,
                     cycle_count, m_tdata[71:65]);
            show_reading("want", want_rd);
            show_reading("got ", got_rd);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding", cycle_count,
               pending_readings.size());
      $display("sensor_avg_minmax_normalizer_core: mismatch");
      $finish;
    end
  end

  initial begin
    int c;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    err_count   = 0;
    cycle_count = 0;
    rounds_sent = 0;
    readings_checked = 0;
    invalid_seen     = 0;
    zero_span_seen   = 0;
    rounds_seen = '0;
    for (c = 0; c < NCH; c++) begin
      round_sums[c] = '0;
      span_lo[c] = (c == 2 || c == 3) ? 12'd999 : 12'd120;
      span_hi[c] = (c == 2 || c == 3) ? 12'd999 : 12'd2500;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_zero_span();
    test_dark_inner();
    test_random_sets(0, 0, 16);
    test_random_sets(66, 0, 16);
    test_random_sets(0, 66, 16);
    test_random_sets(13, 13, 16);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d rounds sent, %0d readings checked (%0d with zero centroid weight,",
             rounds_sent, readings_checked, invalid_seen);
    $display("%0d with a zero span) over four idle/stall phases", zero_span_seen);
    if (err_count == 0) begin
      $display("sensor_avg_minmax_normalizer_core: match");
    end else begin
      $display("%0d failures", err_count);
      $display("sensor_avg_minmax_normalizer_core: mismatch");
    end
    $finish;
  end

endmodule

[sensor_avg_minmax_normalizer_core.f]
hdl/samn_pkg.sv
hdl/samn_div.sv
hdl/sensor_avg_minmax_normalizer_core.sv
tb/tb_top.sv
